/* hdl/mm_pkg.sv */
`default_nettype none

package mm_pkg;

    localparam int DATA_W      = 32;
    localparam int POS_W       = 3;
    localparam int DIM_W       = 4;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int TDATA_W     = 40;
    localparam int IN_TUSER_W  = KIND_W;
    localparam int OUT_TUSER_W = 1;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [KIND_W-1:0] KIND_WR_A    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_B    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef logic [DIM_W-1:0] dim_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

    function automatic dim_t clamp_dim(input dim_t v, input dim_t max_dim);
        dim_t d;
        d = v;
        if (d == '0)
        begin
            d = DIM_W'(1);
        end
        if (d > max_dim)
        begin
            d = max_dim;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* hdl/mm_ram.sv */
`default_nettype none

module mm_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [ADDR_W-1:0]         waddr,
    input  wire logic [mm_pkg::DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]         raddr,
    output logic      [mm_pkg::DATA_W-1:0] rdata
);
    import mm_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/mm_mac.sv */
`default_nettype none

module mm_mac #(
    parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mm_pkg::mac_ctrl_t                ctl,
    input  wire logic signed [mm_pkg::DATA_W-1:0] a_data,
    input  wire logic signed [mm_pkg::DATA_W-1:0] b_data,
    output logic                                  done,
    output logic             [mm_pkg::DATA_W-1:0] result
);
    import mm_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

    mac_ctrl_t                 ctl_rd_reg;
    mac_ctrl_t                 ctl_mul_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      done_reg;
    logic signed [ACC_W-1:0]   shifted;
    logic                      fits;

    // read data arrives in the cycle after issue; multiply; then accumulate
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl_mul_reg.valid)
        begin
            acc_next = (ctl_mul_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_rd_reg  <= '0;
            ctl_mul_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            ctl_rd_reg  <= ctl;
            ctl_mul_reg <= ctl_rd_reg;
            done_reg    <= ctl_mul_reg.valid && ctl_mul_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_data * b_data;
        acc_reg  <= acc_next;
    end

    assign shifted = acc_reg >>> FRAC_BITS;
    assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || (~|shifted[ACC_W-1:DATA_W-1]);
    assign result  = fits ? shifted[DATA_W-1:0] : (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX);
    assign done    = done_reg;

endmodule

`default_nettype wire

/* hdl/matrix_multiply.sv */
// Fixed-point matrix product C = A * B (signed Q16.16, up to MAX_DIM x MAX_DIM).
// Element writes (tuser kind 0 for A, 1 for B) are taken one per cycle while idle and store
// into two on-chip RAMs; their contents are undefined until written and no clearing pass
// runs after reset, so every element a product uses must be written first. A compute request
// (kind 2) holds the input until the run finishes: for each element of C the run issues one
// RAM read pair per cycle into one 32x32 multiplier, then waits for the read, multiply and
// accumulate steps and emits the result once the output register is free. A dimension
// mismatch (a_cols != b_rows) gives one result with tuser set and tlast set. Sums are exact,
// shifted right arithmetically by FRAC_BITS and saturated to 32 bits. Configure only while
// idle.
`default_nettype none

module matrix_multiply #(
    parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // row_index[2:0], col_index[5:3], element_value[37:6], zero pad
    input  wire logic [mm_pkg::TDATA_W-1:0]         s_axis_tdata,
    // kind[1:0]
    input  wire logic [mm_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // out_row[2:0], out_col[5:3], product_value[37:6], zero pad
    output logic      [mm_pkg::TDATA_W-1:0]         m_axis_tdata,
    // dim_error[0]
    output logic      [mm_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mm_pkg::DIM_W-1:0]           cfg_data
);
    import mm_pkg::*;

    localparam int   IDX_W  = $clog2(MAX_DIM);
    localparam int   DEPTH  = MAX_DIM * MAX_DIM;
    localparam int   ADDR_W = $clog2(DEPTH);
    localparam dim_t MAX_D  = DIM_W'(MAX_DIM);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_FLUSH,
        S_EMIT,
        S_ERR
    } state_t;

    state_t             state_reg, state_next;
    dim_t               a_rows_reg, a_rows_next;
    dim_t               a_cols_reg, a_cols_next;
    dim_t               b_rows_reg, b_rows_next;
    dim_t               b_cols_reg, b_cols_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               m_valid_reg, m_valid_next;
    logic [POS_W-1:0]   m_row_reg, m_row_next;
    logic [POS_W-1:0]   m_col_reg, m_col_next;
    logic [DATA_W-1:0]  m_value_reg, m_value_next;
    logic               m_err_reg, m_err_next;
    logic               m_last_reg, m_last_next;

    logic [POS_W-1:0]   in_row;
    logic [POS_W-1:0]   in_col;
    logic [DATA_W-1:0]  in_val;
    logic               pos_ok;
    logic               a_we, b_we;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  a_raddr, b_raddr;
    logic [DATA_W-1:0]  a_rdata, b_rdata;
    mac_ctrl_t          issue;
    logic               mac_done;
    logic [DATA_W-1:0]  mac_result;
    logic               out_free;
    logic               last_k, last_c, last_r;

    assign in_row = s_axis_tdata[POS_W-1:0];
    assign in_col = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_val = s_axis_tdata[2*POS_W+DATA_W-1:2*POS_W];
    assign pos_ok = ({1'b0, in_row} < MAX_D) && ({1'b0, in_col} < MAX_D);
    assign waddr  = ADDR_W'(in_row[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
                  + ADDR_W'(in_col[IDX_W-1:0]);

    assign a_raddr = ADDR_W'(row_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
    assign b_raddr = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(col_reg);

    assign last_k = (DIM_W'(k_reg) + DIM_W'(1)) == a_cols_reg;
    assign last_c = (DIM_W'(col_reg) + DIM_W'(1)) == b_cols_reg;
    assign last_r = (DIM_W'(row_reg) + DIM_W'(1)) == a_rows_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // RAM writes only in idle and reads only during a run, so no same-entry overlap
    always_comb
    begin
        state_next   = state_reg;
        a_rows_next  = a_rows_reg;
        a_cols_next  = a_cols_reg;
        b_rows_next  = b_rows_reg;
        b_cols_next  = b_cols_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_value_next = m_value_reg;
        m_err_next   = m_err_reg;
        m_last_next  = m_last_reg;
        a_we         = 1'b0;
        b_we         = 1'b0;
        issue        = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_A_ROWS: a_rows_next = clamp_dim(cfg_data, MAX_D);
                REG_A_COLS: a_cols_next = clamp_dim(cfg_data, MAX_D);
                REG_B_ROWS: b_rows_next = clamp_dim(cfg_data, MAX_D);
                REG_B_COLS: b_cols_next = clamp_dim(cfg_data, MAX_D);
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        KIND_WR_A: a_we = pos_ok;
                        KIND_WR_B: b_we = pos_ok;
                        KIND_COMPUTE:
                        begin
                            if (a_cols_reg != b_rows_reg)
                            begin
                                state_next = S_ERR;
                            end
                            else
                            begin
                                row_next   = '0;
                                col_next   = '0;
                                k_next     = '0;
                                state_next = S_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE:
            begin
                issue.valid = 1'b1;
                issue.first = (k_reg == '0);
                issue.last  = last_k;
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = S_FLUSH;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_FLUSH:
            begin
                if (mac_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_row_next   = POS_W'(row_reg);
                    m_col_next   = POS_W'(col_reg);
                    m_value_next = mac_result;
                    m_err_next   = 1'b0;
                    m_last_next  = last_r && last_c;
                    if (last_r && last_c)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (last_c)
                        begin
                            col_next = '0;
                            row_next = row_reg + IDX_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + IDX_W'(1);
                        end
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_row_next   = '0;
                    m_col_next   = '0;
                    m_value_next = '0;
                    m_err_next   = 1'b1;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            a_rows_reg  <= MAX_D;
            a_cols_reg  <= MAX_D;
            b_rows_reg  <= MAX_D;
            b_cols_reg  <= MAX_D;
            row_reg     <= '0;
            col_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            m_row_reg   <= '0;
            m_col_reg   <= '0;
            m_value_reg <= '0;
            m_err_reg   <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_rows_reg  <= a_rows_next;
            a_cols_reg  <= a_cols_next;
            b_rows_reg  <= b_rows_next;
            b_cols_reg  <= b_cols_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            m_row_reg   <= m_row_next;
            m_col_reg   <= m_col_next;
            m_value_reg <= m_value_next;
            m_err_reg   <= m_err_next;
            m_last_reg  <= m_last_next;
        end
    end

    mm_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (in_val),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mm_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (in_val),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mm_mac #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (issue),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .done   (mac_done),
        .result (mac_result)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - 2*POS_W - DATA_W){1'b0}},
                            m_value_reg, m_col_reg, m_row_reg};
    assign m_axis_tuser  = m_err_reg;
    assign m_axis_tlast  = m_last_reg;

    a_done_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_FLUSH))
        else $error("accumulate finished outside flush");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_err_reg) |-> m_last_reg)
        else $error("error result not marked last");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |-> ((DIM_W'(k_reg) < a_cols_reg)
                                    && (DIM_W'(row_reg) < a_rows_reg)
                                    && (DIM_W'(col_reg) < b_cols_reg)))
        else $error("run counter out of range");

endmodule

`default_nettype wire

/* test/matrix_multiply_test.sv */
`timescale 1ns / 100ps

module matrix_multiply_test;

    localparam int MAX_DIM   = mm_pkg::MAX_DIM_DEF;
    localparam int FRAC_BITS = mm_pkg::FRAC_BITS_DEF;
    localparam int SETTLE    = 24;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 210;

    localparam logic [mm_pkg::KIND_W-1:0]    KIND_NOP  = 2'd3;
    localparam logic [mm_pkg::CFG_IDX_W-1:0] REG_NONE  = 3'd5;
    localparam logic signed [127:0] Q_HI = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] Q_LO = -128'sh8000_0000;

    typedef enum logic [1:0] {REQ_ELEMENT, REQ_SETUP} req_kind_t;

    typedef struct {
        req_kind_t                     what;
        logic [mm_pkg::KIND_W-1:0]     kind;
        logic [mm_pkg::POS_W-1:0]      row;
        logic [mm_pkg::POS_W-1:0]      col;
        logic [mm_pkg::DATA_W-1:0]     value;
        logic [mm_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [mm_pkg::DIM_W-1:0]      reg_val;
        logic                          calm;
    } request_t;

    typedef struct {
        logic [mm_pkg::POS_W-1:0]  row;
        logic [mm_pkg::POS_W-1:0]  col;
        logic [mm_pkg::DATA_W-1:0] value;
        logic                      err;
        logic                      last;
    } product_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [mm_pkg::TDATA_W-1:0]        s_axis_tdata = '0;
    logic [mm_pkg::IN_TUSER_W-1:0]     s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [mm_pkg::TDATA_W-1:0]        m_axis_tdata;
    logic [mm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser;
    logic                              m_axis_tlast;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [mm_pkg::DIM_W-1:0]          cfg_data = '0;

    request_t pending_q[$];
    product_t product_q[$];

    // predictor state
    logic signed [mm_pkg::DATA_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [mm_pkg::DATA_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    int dim_now [4] = '{8, 8, 8, 8};

    // stimulus bookkeeping
    int  gen_dim [4] = '{8, 8, 8, 8};
    bit  a_done [MAX_DIM*MAX_DIM];
    bit  b_done [MAX_DIM*MAX_DIM];
    int  item_count = 0;
    bit  calm_now = 1'b0;

    logic in_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic calm = 1'b0;
    int   quiet_cycles = 0;
    int   stall_cycles = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   mismatches = 0;

    matrix_multiply uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int fit_dim(input logic [mm_pkg::DIM_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // exact sum, floor shift, saturate
    function automatic logic [mm_pkg::DATA_W-1:0] dot_q16(input int r, input int c);
        logic signed [127:0] acc;
        logic signed [127:0] shifted;
        acc = '0;
        for (int k = 0; k < dim_now[mm_pkg::REG_A_COLS]; k++)
        begin
            acc = acc + a_mem[r*MAX_DIM+k] * b_mem[k*MAX_DIM+c];
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > Q_HI)
        begin
            return mm_pkg::SAT_MAX;
        end
        if (shifted < Q_LO)
        begin
            return mm_pkg::SAT_MIN;
        end
        return shifted[mm_pkg::DATA_W-1:0];
    endfunction

    task automatic predict_request(input request_t req);
        product_t p;
        int rows;
        int cols;
        rows = dim_now[mm_pkg::REG_A_ROWS];
        cols = dim_now[mm_pkg::REG_B_COLS];
        case (req.kind)
            mm_pkg::KIND_WR_A: a_mem[req.row*MAX_DIM+req.col] = req.value;
            mm_pkg::KIND_WR_B: b_mem[req.row*MAX_DIM+req.col] = req.value;
            mm_pkg::KIND_COMPUTE:
            begin
                if (dim_now[mm_pkg::REG_A_COLS] != dim_now[mm_pkg::REG_B_ROWS])
                begin
                    p = '{row: '0, col: '0, value: '0, err: 1'b1, last: 1'b1};
                    product_q.insert(product_q.size(), p);
                end
                else
                begin
                    for (int r = 0; r < rows; r++)
                    begin
                        for (int c = 0; c < cols; c++)
                        begin
                            p.row   = r[mm_pkg::POS_W-1:0];
                            p.col   = c[mm_pkg::POS_W-1:0];
                            p.value = dot_q16(r, c);
                            p.err   = 1'b0;
                            p.last  = (r == rows - 1) && (c == cols - 1);
                            product_q.insert(product_q.size(), p);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_element(input logic [mm_pkg::KIND_W-1:0] kind, input int row,
                                input int col, input logic [mm_pkg::DATA_W-1:0] value);
        request_t req;
        req = '{what: REQ_ELEMENT, kind: kind, row: row[mm_pkg::POS_W-1:0],
                col: col[mm_pkg::POS_W-1:0], value: value, reg_idx: '0, reg_val: '0,
                calm: calm_now};
        pending_q.insert(pending_q.size(), req);
        if (kind == mm_pkg::KIND_WR_A)
        begin
            a_done[row*MAX_DIM+col] = 1'b1;
        end
        if (kind == mm_pkg::KIND_WR_B)
        begin
            b_done[row*MAX_DIM+col] = 1'b1;
        end
        if (kind != KIND_NOP)
        begin
            item_count++;
        end
    endtask

    task automatic push_setup(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                              input logic [mm_pkg::DIM_W-1:0] value);
        request_t req;
        req = '{what: REQ_SETUP, kind: '0, row: '0, col: '0, value: '0, reg_idx: idx,
                reg_val: value, calm: calm_now};
        pending_q.insert(pending_q.size(), req);
        if (idx <= mm_pkg::REG_B_COLS)
        begin
            gen_dim[idx] = fit_dim(value);
        end
    endtask

    // write a dimension register if needed or at random, sometimes through an out-of-range alias
    task automatic tune(input logic [mm_pkg::CFG_IDX_W-1:0] idx, input int want);
        logic [mm_pkg::DIM_W-1:0] raw;
        int alias_val;
        raw = want[mm_pkg::DIM_W-1:0];
        if (want == MAX_DIM && $urandom_range(0, 1) == 0)
        begin
            alias_val = $urandom_range(MAX_DIM + 1, 15);
            raw = alias_val[mm_pkg::DIM_W-1:0];
        end
        if (want == 1 && $urandom_range(0, 2) == 0)
        begin
            raw = '0;
        end
        if (gen_dim[idx] != want || $urandom_range(0, 5) == 0)
        begin
            push_setup(idx, raw);
        end
    endtask

    function automatic logic [mm_pkg::DATA_W-1:0] rand_q16();
        logic [mm_pkg::DATA_W-1:0] small_val;
        small_val = $urandom_range(0, 32'h0004_0000);
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2:    return mm_pkg::SAT_MAX;
            3:    return mm_pkg::SAT_MIN;
            4:    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom_range(0, 1) ? small_val : -small_val;
        endcase
    endfunction

    task automatic run_product(input bit big);
        int want [4];
        int pos_q[$];
        int pick;
        int p;
        int reg_pick;
        int val_pick;
        if (big)
        begin
            want = '{MAX_DIM, 2, 2, MAX_DIM};
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                want[i] = ($urandom_range(0, 11) == 0) ? MAX_DIM : $urandom_range(1, 3);
            end
            want[mm_pkg::REG_B_ROWS] = want[mm_pkg::REG_A_COLS];
            if ($urandom_range(0, 4) == 0)
            begin
                want[mm_pkg::REG_B_ROWS] = (want[mm_pkg::REG_A_COLS] % MAX_DIM) + 1;
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            reg_pick = int'(REG_NONE) + $urandom_range(0, 2);
            val_pick = $urandom_range(0, 15);
            push_setup(reg_pick[mm_pkg::CFG_IDX_W-1:0], val_pick[mm_pkg::DIM_W-1:0]);
        end
        tune(mm_pkg::REG_A_ROWS, want[mm_pkg::REG_A_ROWS]);
        tune(mm_pkg::REG_A_COLS, want[mm_pkg::REG_A_COLS]);
        tune(mm_pkg::REG_B_ROWS, want[mm_pkg::REG_B_ROWS]);
        tune(mm_pkg::REG_B_COLS, want[mm_pkg::REG_B_COLS]);

        for (int r = 0; r < want[mm_pkg::REG_A_ROWS]; r++)
        begin
            for (int c = 0; c < want[mm_pkg::REG_A_COLS]; c++)
            begin
                if (!a_done[r*MAX_DIM+c] || $urandom_range(0, 2) == 0)
                begin
                    pos_q.insert(pos_q.size(), r*MAX_DIM + c);
                end
            end
        end
        for (int r = 0; r < want[mm_pkg::REG_B_ROWS]; r++)
        begin
            for (int c = 0; c < want[mm_pkg::REG_B_COLS]; c++)
            begin
                if (!b_done[r*MAX_DIM+c] || $urandom_range(0, 2) == 0)
                begin
                    pos_q.insert(pos_q.size(), MAX_DIM*MAX_DIM + r*MAX_DIM + c);
                end
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) pos_q.insert(pos_q.size(), $urandom_range(0, 127));
        end

        while (pos_q.size() > 0)
        begin
            pick = $urandom_range(0, pos_q.size() - 1);
            p = pos_q[pick];
            pos_q.delete(pick);
            if ($urandom_range(0, 15) == 0)
            begin
                push_element(KIND_NOP, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
            end
            push_element(p >= MAX_DIM*MAX_DIM ? mm_pkg::KIND_WR_B : mm_pkg::KIND_WR_A,
                         (p / MAX_DIM) % MAX_DIM, p % MAX_DIM, rand_q16());
        end
        push_element(mm_pkg::KIND_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom());
    endtask

    initial
    begin
        int target;
        int kind_pick;

        // directed: register clamping, saturation, floor rounding, mismatch, unknown kind
        push_setup(REG_NONE, 4'd3);
        push_setup(mm_pkg::REG_A_ROWS, 4'd0);
        push_setup(mm_pkg::REG_A_COLS, 4'd1);
        push_setup(mm_pkg::REG_B_ROWS, 4'd1);
        push_setup(mm_pkg::REG_B_COLS, 4'd0);
        push_element(KIND_NOP, 7, 7, 32'hFFFF_FFFF);
        push_element(mm_pkg::KIND_WR_A, 0, 0, mm_pkg::SAT_MAX);
        push_element(mm_pkg::KIND_WR_B, 0, 0, mm_pkg::SAT_MAX);
        push_element(mm_pkg::KIND_COMPUTE, 0, 0, '0);
        push_element(mm_pkg::KIND_WR_A, 0, 0, mm_pkg::SAT_MIN);
        push_element(mm_pkg::KIND_COMPUTE, 7, 7, 32'hFFFF_FFFF);
        push_element(mm_pkg::KIND_WR_B, 0, 0, mm_pkg::SAT_MIN);
        push_element(mm_pkg::KIND_COMPUTE, 0, 0, '0);
        push_element(mm_pkg::KIND_WR_A, 0, 0, 32'h0000_0001);
        push_element(mm_pkg::KIND_WR_B, 0, 0, 32'hFFFF_FFFF);
        push_element(mm_pkg::KIND_COMPUTE, 0, 0, '0);
        push_element(mm_pkg::KIND_WR_A, 0, 0, 32'h0001_8000);
        push_element(mm_pkg::KIND_WR_B, 0, 0, 32'hFFFE_8000);
        push_element(mm_pkg::KIND_COMPUTE, 0, 0, '0);
        push_setup(mm_pkg::REG_B_ROWS, 4'd2);
        push_element(mm_pkg::KIND_COMPUTE, 0, 0, '0);
        push_element(mm_pkg::KIND_WR_A, 7, 7, 32'h0);
        push_element(mm_pkg::KIND_WR_B, 7, 7, 32'hA5A5_5A5A);
        push_setup(mm_pkg::REG_A_COLS, 4'd15);
        push_setup(mm_pkg::REG_B_ROWS, 4'd9);

        target = item_count + RANDOM_ITEMS;
        run_product(1'b1);
        while (item_count < target)
        begin
            calm_now = (item_count >= target - 40) || ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    kind_pick = $urandom_range(0, 3);
                    push_element(kind_pick[mm_pkg::KIND_W-1:0], $urandom_range(0, 7),
                                 $urandom_range(0, 7), rand_q16());
                end
            end
            else
            begin
                run_product(1'b0);
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid || cfg_valid || product_q.size() != 0
               || quiet_cycles < SETTLE)
        begin
            @(posedge clk);
        end
        if (mismatches == 0)
        begin
            $display("** matrix_multiply: PASSED **");
        end
        else
        begin
            $display("** matrix_multiply: FAILED **");
        end
        $finish;
    end

    // driver: requests are predicted when first presented, since they are then committed
    always @(negedge clk)
    begin : feed
        logic vld;
        logic cvld;
        request_t req;
        vld  = s_axis_tvalid;
        cvld = cfg_valid;
        if (in_taken)
        begin
            vld = 1'b0;
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                gap_left = $urandom_range(1, 10);
            end
        end
        if (cfg_taken)
        begin
            cvld = 1'b0;
        end
        if (rst_n && !vld && !cvld)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_q.size() > 0)
            begin
                req = pending_q[0];
                if (req.what == REQ_ELEMENT)
                begin
                    void'(pending_q.pop_front());
                    predict_request(req);
                    s_axis_tdata <= {2'b00, req.value, req.col, req.row};
                    s_axis_tuser <= req.kind;
                    calm <= req.calm;
                    vld = 1'b1;
                end
                else if (quiet_cycles >= SETTLE)
                begin
                    void'(pending_q.pop_front());
                    if (req.reg_idx <= mm_pkg::REG_B_COLS)
                    begin
                        dim_now[req.reg_idx] = fit_dim(req.reg_val);
                    end
                    cfg_index <= req.reg_idx;
                    cfg_data  <= req.reg_val;
                    calm <= req.calm;
                    cvld = 1'b1;
                end
            end
        end
        s_axis_tvalid <= vld;
        cfg_valid     <= cvld;
    end

    always @(negedge clk)
    begin : sink
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rst_n && !calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= rst_n;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // monitor and watchdog
    always @(posedge clk)
    begin : watch
        product_t want;
        logic result_taken;
        if (rst_n)
        begin
            result_taken = m_axis_tvalid && m_axis_tready;
            in_taken  <= s_axis_tvalid && s_axis_tready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (result_taken)
            begin
                if (product_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result tdata %h tuser %b tlast %b",
                                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
                end
                else
                begin
                    want = product_q.pop_front();
                    if (m_axis_tdata[2:0] !== want.row || m_axis_tdata[5:3] !== want.col
                        || m_axis_tdata[37:6] !== want.value
                        || m_axis_tuser[0] !== want.err || m_axis_tlast !== want.last)
                    begin
                        report_mismatch($sformatf(
                            "exp row %0d col %0d val %h err %b last %b, got %0d %0d %h %b %b",
                            want.row, want.col, want.value, want.err, want.last,
                            m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6],
                            m_axis_tuser[0], m_axis_tlast));
                    end
                end
            end
            if (product_q.size() == 0 && !s_axis_tvalid && !cfg_valid && !result_taken)
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            else
            begin
                quiet_cycles <= 0;
            end
            if (result_taken || (s_axis_tvalid && s_axis_tready) || (cfg_valid && cfg_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("** matrix_multiply: FAILED **");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule
